[rtl/fbgb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbgb_pkg
// Shared types, constants and helpers of the rotated framebuffer glyph blitter.
// ----------------------------------------------------------------------------
package fbgb_pkg;

  localparam int unsigned SCREEN_ROWS = 240;
  localparam int unsigned PIXEL_BYTES = 3;
  localparam int unsigned GLYPH_WIDTH = 8;

  // Byte distance between two horizontally adjacent pixels (one column).
  localparam logic [31:0] COL_STRIDE = 32'(PIXEL_BYTES * SCREEN_ROWS);

  typedef logic [GLYPH_WIDTH-1:0]         lane_mask_t;
  typedef logic [$clog2(GLYPH_WIDTH)-1:0] lane_idx_t;

  typedef enum logic {
    OP_FILL  = 1'b0,
    OP_GLYPH = 1'b1
  } opcode_t;

  // One classified row command: lane i is the i-th pixel from the left.
  typedef struct packed {
    logic [31:0] start;   // byte address of the leftmost pixel
    lane_mask_t  mask;    // lanes that get a write
    lane_mask_t  pat;     // 1 selects fg, 0 selects bg
    logic [23:0] fg;
    logic [23:0] bg;
  } blit_cmd_t;

  function automatic logic [31:0] lane_offset(lane_idx_t idx);
    return 32'(idx) * COL_STRIDE;
  endfunction

endpackage

[rtl/fbgb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbgb_front
// Accepts row commands, works out the start address and the lane masks.
// ----------------------------------------------------------------------------
module fbgb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic [31:0]           fb_base,
  input  logic [8:0]            x_pos,
  input  logic [7:0]            y_pos,
  input  logic [3:0]            span_len,
  input  logic [7:0]            glyph_row,
  input  logic [23:0]           fg_color,
  input  logic [23:0]           bg_color,
  input  logic                  bg_transparent,
  output logic                  q_push,
  output fbgb_pkg::blit_cmd_t   q_data,
  input  logic                  q_full
);

  logic                 fvalid;
  fbgb_pkg::blit_cmd_t  cmd;
  fbgb_pkg::blit_cmd_t  cmd_next;
  logic [3:0]           len_clip;
  logic [31:0]          col_off;
  logic [31:0]          row_off;
  logic                 accept;

  assign q_push   = fvalid && !q_full;
  assign in_ready = !fvalid || q_push;
  assign accept   = in_valid && in_ready;
  assign q_data   = cmd;

  always_comb begin
    len_clip = (span_len > 4'(fbgb_pkg::GLYPH_WIDTH)) ? 4'(fbgb_pkg::GLYPH_WIDTH) : span_len;
    col_off  = 32'(x_pos) * fbgb_pkg::COL_STRIDE;
    row_off  = (32'(fbgb_pkg::SCREEN_ROWS - 1) - 32'(y_pos)) * 32'(fbgb_pkg::PIXEL_BYTES);
    cmd_next.start = fb_base + col_off + row_off;
    cmd_next.fg    = fg_color;
    cmd_next.bg    = bg_color;
    for (int i = 0; i < fbgb_pkg::GLYPH_WIDTH; i++) begin
      if (fbgb_pkg::opcode_t'(opcode) == fbgb_pkg::OP_GLYPH) begin
        cmd_next.pat[i]  = glyph_row[fbgb_pkg::GLYPH_WIDTH-1-i];
        cmd_next.mask[i] = glyph_row[fbgb_pkg::GLYPH_WIDTH-1-i] || !bg_transparent;
      end else begin
        cmd_next.pat[i]  = 1'b1;
        cmd_next.mask[i] = 4'(i) < len_clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (accept) begin
      // drop commands that draw nothing
      fvalid <= (cmd_next.mask != '0);
    end else if (q_push) begin
      fvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

[rtl/fbgb_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbgb_cmd_queue
// Small flop-based command queue between the front and back halves.
// ----------------------------------------------------------------------------
module fbgb_cmd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fbgb_pkg::blit_cmd_t  push_data,
  output logic                 full,
  input  logic                 pop,
  output fbgb_pkg::blit_cmd_t  pop_data,
  output logic                 empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  fbgb_pkg::blit_cmd_t entries [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [CW-1:0]       count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/fbgb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbgb_back
// Walks a command's lanes: one pixel write per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module fbgb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  fbgb_pkg::blit_cmd_t  q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          byte_address,
  output logic [7:0]           blue,
  output logic [7:0]           green,
  output logic [7:0]           red,
  output logic                 last
);

  logic                 cur_valid;
  fbgb_pkg::blit_cmd_t  cur;
  fbgb_pkg::lane_mask_t rem;
  fbgb_pkg::lane_mask_t rem_next;
  fbgb_pkg::lane_idx_t  idx;
  fbgb_pkg::lane_mask_t sel;
  logic [23:0]          color;
  logic                 cur_last;
  logic                 out_load;
  logic                 emit;

  always_comb begin
    // pick the leftmost lane still pending
    idx = '0;
    for (int i = fbgb_pkg::GLYPH_WIDTH - 1; i >= 0; i--) begin
      if (rem[i]) begin
        idx = fbgb_pkg::lane_idx_t'(i);
      end
    end
    sel      = fbgb_pkg::lane_mask_t'(1) << idx;
    rem_next = rem & ~sel;
    cur_last = (rem_next == '0);
    color    = cur.pat[idx] ? cur.fg : cur.bg;
    out_load = !out_valid || out_ready;
    emit     = cur_valid && out_load;
    q_pop    = !q_empty && (!cur_valid || (emit && cur_last));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (emit && cur_last) begin
        cur_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
      rem <= q_data.mask;
    end else if (emit) begin
      rem <= rem_next;
    end
    if (emit) begin
      byte_address <= cur.start + fbgb_pkg::lane_offset(idx);
      blue         <= color[23:16];
      green        <= color[15:8];
      red          <= color[7:0];
      last         <= cur_last;
    end
  end

endmodule

[rtl/rotated_framebuffer_glyph_blitter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_framebuffer_glyph_blitter_unit
// Turns row commands (fill span, glyph row) into per-pixel framebuffer writes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) takes one row command per item.
//   A fill paints up to eight pixels in fg_color; a glyph row paints set bits
//   in fg_color and clear bits in bg_color unless bg_transparent is high.
//   The output channel (out_valid / out_ready) carries one pixel write per
//   item, left to right, with last high on the final write of a command.
//   Commands that draw nothing produce no output at all.
//   Path: the first write of a command passes through the front register,
//   the command queue, the current-command register and the output register.
//   Throughput: one pixel write per cycle while the receiver is ready, set
//   by the single output register; a command draws 1 to 8 pixels, and
//   back-to-back commands follow each other with no gap.
//   The front half keeps accepting while the back half drains, until the
//   command queue (QUEUE_DEPTH entries) and the front register are full.
//   When the receiver stalls, the current write holds on the output ports and
//   the queue and the front register fill, after which in_ready drops.
//   Reset (rst, synchronous) empties the front register, the queue and the
//   output register; in_ready is high the cycle after reset.
// ----------------------------------------------------------------------------
module rotated_framebuffer_glyph_blitter_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [31:0] fb_base,
  input  logic [8:0]  x_pos,
  input  logic [7:0]  y_pos,
  input  logic [3:0]  span_len,
  input  logic [7:0]  glyph_row,
  input  logic [23:0] fg_color,
  input  logic [23:0] bg_color,
  input  logic        bg_transparent,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] byte_address,
  output logic [7:0]  blue,
  output logic [7:0]  green,
  output logic [7:0]  red,
  output logic        last
);

  // Queue handshake between the two halves.
  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_empty;
  fbgb_pkg::blit_cmd_t  q_wdata;
  fbgb_pkg::blit_cmd_t  q_rdata;

  // Front: accept, compute start address and lane masks, drop empty rows.
  fbgb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .fb_base        (fb_base),
    .x_pos          (x_pos),
    .y_pos          (y_pos),
    .span_len       (span_len),
    .glyph_row      (glyph_row),
    .fg_color       (fg_color),
    .bg_color       (bg_color),
    .bg_transparent (bg_transparent),
    .q_push         (q_push),
    .q_data         (q_wdata),
    .q_full         (q_full)
  );

  // Decouple the halves so either side can stall on its own.
  fbgb_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Back: walk pending lanes, one registered write per cycle when not stalled.
  fbgb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_address (byte_address),
    .blue         (blue),
    .green        (green),
    .red          (red),
    .last         (last)
  );

  // Reset leaves no write pending and the input open.
  a_reset_state : assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // A taken write that is not the last of its command is followed at once.
  a_no_gap_in_row : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("gap inside a row command");

  // The back half never pops an empty queue, and the front never overfills it.
  a_queue_safe : assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty) && !(q_push && q_full))
    else $error("command queue misuse");

endmodule

[tb/blit_write_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_write_checker
// Watches both channels of the glyph blitter, expands every accepted row
// command into the pixel writes it must produce, and compares them in order
// with the writes that leave the block.
// ----------------------------------------------------------------------------
module blit_write_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        opcode,
  input  logic [31:0] fb_base,
  input  logic [8:0]  x_pos,
  input  logic [7:0]  y_pos,
  input  logic [3:0]  span_len,
  input  logic [7:0]  glyph_row,
  input  logic [23:0] fg_color,
  input  logic [23:0] bg_color,
  input  logic        bg_transparent,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] byte_address,
  input  logic [7:0]  blue,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  input  logic        last,
  output int          mismatch_count,
  output int          writes_due
);

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        last;
  } pixel_write_t;

  pixel_write_t pixel_writes_due[$];

  // Append the writes of one row command, leftmost pixel first.
  function automatic void expand_row_command(
    input fbgb_pkg::opcode_t op,
    input logic [31:0]       base,
    input logic [8:0]        x,
    input logic [7:0]        y,
    input logic [3:0]        len,
    input logic [7:0]        row,
    input logic [23:0]       fg,
    input logic [23:0]       bg,
    input logic              transparent
  );
    logic [31:0]  addr;
    logic [7:0]   drawn_lanes;
    logic [7:0]   fg_lanes;
    logic [23:0]  color;
    int           span;
    int           total;
    int           k;
    pixel_write_t w;
    addr = base + 32'(x) * fbgb_pkg::COL_STRIDE
         + (32'(fbgb_pkg::SCREEN_ROWS) - 32'd1 - 32'(y)) * 32'(fbgb_pkg::PIXEL_BYTES);
    if (op == fbgb_pkg::OP_FILL) begin
      span = (len > fbgb_pkg::GLYPH_WIDTH) ? fbgb_pkg::GLYPH_WIDTH : int'(len);
      drawn_lanes = 8'hFF << (fbgb_pkg::GLYPH_WIDTH - span);
      fg_lanes = 8'hFF;
    end else begin
      drawn_lanes = transparent ? row : 8'hFF;
      fg_lanes = row;
    end
    total = $countones(drawn_lanes);
    k = 0;
    for (int i = 0; i < fbgb_pkg::GLYPH_WIDTH; i++) begin
      if (drawn_lanes[fbgb_pkg::GLYPH_WIDTH-1-i]) begin
        color = fg_lanes[fbgb_pkg::GLYPH_WIDTH-1-i] ? fg : bg;
        w.addr = addr;
        w.blue = color[23:16];
        w.green = color[15:8];
        w.red = color[7:0];
        w.last = (k == total - 1);
        pixel_writes_due.push_back(w);
        k++;
      end
      addr = addr + fbgb_pkg::COL_STRIDE;
    end
  endfunction

  task automatic log_failure(input string what, input pixel_write_t want,
                             input pixel_write_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"%0t %s: expected addr=%h b=%h g=%h r=%h last=%b, ",
                "got addr=%h b=%h g=%h r=%h last=%b"},
               $time, what, want.addr, want.blue, want.green, want.red, want.last,
               got.addr, got.blue, got.green, got.red, got.last);
  endtask

  always @(posedge clk) begin
    pixel_write_t got;
    pixel_write_t want;
    if (rst) begin
      pixel_writes_due.delete();
      mismatch_count = 0;
      writes_due = 0;
    end else begin
      if (in_valid && in_ready)
        expand_row_command(fbgb_pkg::opcode_t'(opcode), fb_base, x_pos, y_pos,
                           span_len, glyph_row, fg_color, bg_color, bg_transparent);
      if (out_valid && out_ready) begin
        got = '{byte_address, blue, green, red, last};
        if (pixel_writes_due.size() == 0) begin
          log_failure("unexpected write", '0, got);
        end else begin
          want = pixel_writes_due.pop_front();
          if (got.addr !== want.addr || got.blue !== want.blue ||
              got.green !== want.green || got.red !== want.red ||
              got.last !== want.last)
            log_failure("write mismatch", want, got);
        end
      end
      writes_due = pixel_writes_due.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives row commands into the rotated framebuffer glyph blitter with random
// gaps and output stalls; a checker beside the block predicts and compares
// every pixel write, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int HOLD_OFF_CYCLES = 120;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 60;

  typedef struct {
    fbgb_pkg::opcode_t op;
    logic [31:0]       base;
    logic [8:0]        x;
    logic [7:0]        y;
    logic [3:0]        len;
    logic [7:0]        row;
    logic [23:0]       fg;
    logic [23:0]       bg;
    logic              transparent;
  } row_cmd_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [31:0] fb_base;
  logic [8:0]  x_pos;
  logic [7:0]  y_pos;
  logic [3:0]  span_len;
  logic [7:0]  glyph_row;
  logic [23:0] fg_color;
  logic [23:0] bg_color;
  logic        bg_transparent;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] byte_address;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic        last;

  int fail_count;
  int writes_due;

  // Idling controls for the sender and the receiver.
  bit send_calm;
  bit recv_calm;
  bit hold_off_req;

  rotated_framebuffer_glyph_blitter_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .fb_base        (fb_base),
    .x_pos          (x_pos),
    .y_pos          (y_pos),
    .span_len       (span_len),
    .glyph_row      (glyph_row),
    .fg_color       (fg_color),
    .bg_color       (bg_color),
    .bg_transparent (bg_transparent),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_address   (byte_address),
    .blue           (blue),
    .green          (green),
    .red            (red),
    .last           (last)
  );

  blit_write_checker scoreboard (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .fb_base        (fb_base),
    .x_pos          (x_pos),
    .y_pos          (y_pos),
    .span_len       (span_len),
    .glyph_row      (glyph_row),
    .fg_color       (fg_color),
    .bg_color       (bg_color),
    .bg_transparent (bg_transparent),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_address   (byte_address),
    .blue           (blue),
    .green          (green),
    .red            (red),
    .last           (last),
    .mismatch_count (fail_count),
    .writes_due     (writes_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run: the slowest correct run is well under a tenth of this.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic row_cmd_t make_cmd(
    input fbgb_pkg::opcode_t op, input logic [31:0] base, input logic [8:0] x,
    input logic [7:0] y, input logic [3:0] len, input logic [7:0] row,
    input logic [23:0] fg, input logic [23:0] bg, input logic transparent
  );
    row_cmd_t c;
    c = '{op, base, x, y, len, row, fg, bg, transparent};
    return c;
  endfunction

  // Mostly on-screen commands with sane spans; a fraction goes off-screen,
  // overlong or empty, and some bases sit just below the top of the address
  // space so the column stride wraps.
  function automatic row_cmd_t random_cmd();
    row_cmd_t c;
    c.op = fbgb_pkg::opcode_t'($urandom_range(0, 1));
    c.base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 8000)
                                         : $urandom;
    c.x = ($urandom_range(0, 9) < 8) ? 9'($urandom_range(0, 399))
                                     : 9'($urandom_range(400, 511));
    c.y = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 239))
                                     : 8'($urandom_range(240, 255));
    c.len = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 8))
                                       : 4'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0: begin
        c.row = 8'h00;
      end
      1: begin
        c.row = 8'hFF;
      end
      default: begin
        c.row = 8'($urandom);
      end
    endcase
    c.fg = 24'($urandom);
    c.bg = 24'($urandom);
    c.transparent = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Enter and leave at a falling edge. Drop valid only when a gap is wanted,
  // so back-to-back items keep valid high without a glitch.
  task automatic offer_cmd(input row_cmd_t c, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode = c.op;
    fb_base = c.base;
    x_pos = c.x;
    y_pos = c.y;
    span_len = c.len;
    glyph_row = c.row;
    fg_color = c.fg;
    bg_color = c.bg;
    bg_transparent = c.transparent;
    in_valid = 1'b1;
    // Hold the item until the block takes it.
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic int draw_gap();
    return send_calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Receiver: one stall draw per pixel write, plus a long hold-off on request
  // so that the command queue fills and in_ready drops.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      stall = recv_calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    in_valid = 1'b0;
    opcode = fbgb_pkg::OP_FILL;
    fb_base = '0;
    x_pos = '0;
    y_pos = '0;
    span_len = '0;
    glyph_row = '0;
    fg_color = '0;
    bg_color = '0;
    bg_transparent = 1'b0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    hold_off_req = 1'b0;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: span extremes, both opcodes, transparency, ignored operands,
    // screen corners, off-screen positions and address wrap.
    offer_cmd(make_cmd(fbgb_pkg::OP_FILL, 32'h0, 9'd0, 8'd0, 4'd1, 8'h00, 24'hFFFFFF,
                       24'h0, 1'b0), draw_gap());
    offer_cmd(make_cmd(fbgb_pkg::OP_FILL, 32'h1000_0000, 9'd399, 8'd239, 4'd8, 8'hFF,
                       24'h123456, 24'hABCDEF, 1'b1), draw_gap());
    // Zero span: nothing comes out.
    offer_cmd(make_cmd(fbgb_pkg::OP_FILL, 32'h2000_0000, 9'd10, 8'd20, 4'd0, 8'hFF,
                       24'h111111, 24'h222222, 1'b0), draw_gap());
    // Overlong spans clip to eight writes.
    offer_cmd(make_cmd(fbgb_pkg::OP_FILL, 32'h3000_0000, 9'd100, 8'd50, 4'd9, 8'h55,
                       24'h00FF00, 24'hFF0000, 1'b0), draw_gap());
    offer_cmd(make_cmd(fbgb_pkg::OP_FILL, 32'hFFFF_FFFF, 9'd200, 8'd100, 4'd15, 8'hAA,
                       24'hFF00FF, 24'h000000, 1'b1), draw_gap());
    offer_cmd(make_cmd(fbgb_pkg::OP_GLYPH, 32'h4000_0000, 9'd5, 8'd5, 4'd3, 8'hFF,
                       24'hC0FFEE, 24'h0BADF0, 1'b0), draw_gap());
    offer_cmd(make_cmd(fbgb_pkg::OP_GLYPH, 32'h4000_0000, 9'd6, 8'd6, 4'd8, 8'h00,
                       24'hC0FFEE, 24'h0BADF0, 1'b0), draw_gap());
    // Blank row with a transparent background: nothing comes out.
    offer_cmd(make_cmd(fbgb_pkg::OP_GLYPH, 32'h5000_0000, 9'd7, 8'd7, 4'd8, 8'h00,
                       24'hFFFFFF, 24'hFFFFFF, 1'b1), draw_gap());
    offer_cmd(make_cmd(fbgb_pkg::OP_GLYPH, 32'h6000_0000, 9'd8, 8'd8, 4'd1, 8'hA5,
                       24'h010203, 24'h040506, 1'b1), draw_gap());
    offer_cmd(make_cmd(fbgb_pkg::OP_GLYPH, 32'h7000_0000, 9'd9, 8'd9, 4'd0, 8'h5A,
                       24'h0A0B0C, 24'hF0E0D0, 1'b0), draw_gap());
    offer_cmd(make_cmd(fbgb_pkg::OP_GLYPH, 32'h8000_0000, 9'd300, 8'd200, 4'd15, 8'h81,
                       24'h7F7F7F, 24'h808080, 1'b1), draw_gap());
    offer_cmd(make_cmd(fbgb_pkg::OP_GLYPH, 32'h9000_0000, 9'd0, 8'd0, 4'd2, 8'h80,
                       24'hAAAAAA, 24'h555555, 1'b1), draw_gap());
    offer_cmd(make_cmd(fbgb_pkg::OP_GLYPH, 32'hA000_0000, 9'd399, 8'd239, 4'd2, 8'h01,
                       24'h555555, 24'hAAAAAA, 1'b1), draw_gap());
    offer_cmd(make_cmd(fbgb_pkg::OP_FILL, 32'hB000_0000, 9'd511, 8'd255, 4'd4, 8'h00,
                       24'h00000F, 24'h0, 1'b0), draw_gap());
    offer_cmd(make_cmd(fbgb_pkg::OP_GLYPH, 32'h0, 9'd400, 8'd240, 4'd8, 8'hFF,
                       24'hF0F0F0, 24'h0F0F0F, 1'b0), draw_gap());
    offer_cmd(make_cmd(fbgb_pkg::OP_GLYPH, 32'hFFFF_FFFF, 9'd511, 8'd255, 4'd7, 8'h0F,
                       24'h000000, 24'hFFFFFF, 1'b0), draw_gap());
    offer_cmd(make_cmd(fbgb_pkg::OP_FILL, 32'hDEAD_BEEF, 9'd256, 8'd128, 4'd8, 8'h3C,
                       24'h000000, 24'hFFFFFF, 1'b1), draw_gap());

    // Back-pressure: ask the receiver for a long hold-off and keep offering
    // full opaque rows with no gap until in_ready drops and recovers.
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      offer_cmd(make_cmd(fbgb_pkg::OP_GLYPH, $urandom, 9'($urandom_range(0, 399)),
                         8'($urandom_range(0, 239)), 4'($urandom), 8'($urandom),
                         24'($urandom), 24'($urandom), 1'b0), 0);
    end
    // Pause the sender until every write so far has come out.
    in_valid = 1'b0;
    wait (writes_due == 0);
    @(negedge clk);

    // Random phases; each picks its own idling mix so stretches with no gaps
    // and no stalls alternate with fully jittered ones.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      send_calm = (p % 4 == 1) || (p % 4 == 3);
      recv_calm = (p % 4 == 2) || (p % 4 == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        offer_cmd(random_cmd(), draw_gap());
      end
      if (p == 2) begin
        in_valid = 1'b0;
        wait (writes_due == 0);
        @(negedge clk);
      end
    end

    // Drain: wait for every expected write, then watch for stray ones.
    in_valid = 1'b0;
    recv_calm = 1'b0;
    wait (writes_due == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && writes_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
